/* rtl/brprs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// brprs_pkg: shared types and constants of the bitmap priority scheduler
// no dependencies; imported by every scheduler module

package brprs_pkg;

    localparam int KIND_W    = 2;
    localparam int TASK_W    = 4;
    localparam int PRIO_IN_W = 3;
    localparam int SLICE_W   = 16;
    localparam int STATUS_W  = 2;

    typedef logic [TASK_W-1:0]    task_t;
    typedef logic [PRIO_IN_W-1:0] prio_t;
    typedef logic [SLICE_W-1:0]   slice_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_SWITCH = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_READY   = 2'd1,
        STATUS_QUEUE_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SLICE_HOLD   = 2'd0,
        SLICE_LOAD   = 2'd1,
        SLICE_DEC    = 2'd2,
        SLICE_RELOAD = 2'd3
    } slice_op_t;

    // ready bitmap update
    typedef struct packed {
        logic  set;
        logic  clr;
        prio_t level;
    } ready_cmd_t;

    // per-level task queue update
    typedef struct packed {
        logic  push;
        logic  rotate;
        prio_t level;
        task_t task_id;
    } queue_cmd_t;

    // per-task slice counter update
    typedef struct packed {
        slice_op_t op;
        task_t     task_id;
        slice_t    value;
    } slice_cmd_t;

endpackage

`default_nettype wire

/* rtl/brprs_ready_map.sv */
`timescale 1ns / 1ps
`default_nettype none
// brprs_ready_map: ready bitmap register and lowest-set-bit winner search
// depends on brprs_pkg

module brprs_ready_map #(
    parameter int NUM_PRIORITIES = 8,
    localparam int PRIO_W = $clog2(NUM_PRIORITIES)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  brprs_pkg::ready_cmd_t  cmd,
    output logic                   found,
    output logic [PRIO_W-1:0]      win_level
);
    import brprs_pkg::*;

    logic [NUM_PRIORITIES-1:0] ready_reg;
    logic [NUM_PRIORITIES-1:0] ready_next;
    logic [PRIO_W-1:0]         lvl;

    assign lvl = cmd.level[PRIO_W-1:0];

    always_comb
    begin
        ready_next = ready_reg;
        if (cmd.set)
        begin
            ready_next[lvl] = 1'b1;
        end
        if (cmd.clr)
        begin
            ready_next[lvl] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= '0;
        end
        else
        begin
            ready_reg <= ready_next;
        end
    end

    // scan from the highest level down so the lowest set bit is taken last and wins
    always_comb
    begin
        found     = 1'b0;
        win_level = '0;
        for (int p = NUM_PRIORITIES - 1; p >= 0; p--)
        begin
            if (ready_reg[p])
            begin
                found     = 1'b1;
                win_level = PRIO_W'(p);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/brprs_task_queues.sv */
`timescale 1ns / 1ps
`default_nettype none
// brprs_task_queues: one shifting task-id queue per priority level
// depends on brprs_pkg

module brprs_task_queues #(
    parameter int NUM_PRIORITIES = 8,
    parameter int QUEUE_DEPTH    = 16,
    localparam int PRIO_W = $clog2(NUM_PRIORITIES),
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  brprs_pkg::queue_cmd_t cmd,
    output logic [FILL_W-1:0]     fill [NUM_PRIORITIES],
    output brprs_pkg::task_t      head [NUM_PRIORITIES],
    output brprs_pkg::task_t      second [NUM_PRIORITIES]
);
    import brprs_pkg::*;

    // slot 0 is always the queue head, live entries are slots 0 .. fill-1
    task_t             slot_reg [NUM_PRIORITIES][QUEUE_DEPTH];
    logic [FILL_W-1:0] fill_reg [NUM_PRIORITIES];
    logic [PRIO_W-1:0] lvl;

    assign lvl = cmd.level[PRIO_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '{default: '0};
        end
        else if (cmd.push)
        begin
            fill_reg[lvl] <= fill_reg[lvl] + FILL_W'(1);
        end
    end

    // push writes behind the tail, rotate shifts each entry toward the head and wraps the head to the tail
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NUM_PRIORITIES; l++)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (cmd.push && lvl == PRIO_W'(l) && FILL_W'(i) == fill_reg[l])
                begin
                    slot_reg[l][i] <= cmd.task_id;
                end
                else if (cmd.rotate && lvl == PRIO_W'(l))
                begin
                    if (FILL_W'(i + 1) < fill_reg[l])
                    begin
                        slot_reg[l][i] <= slot_reg[l][(i + 1) % QUEUE_DEPTH];
                    end
                    else if (FILL_W'(i + 1) == fill_reg[l])
                    begin
                        slot_reg[l][i] <= slot_reg[l][0];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NUM_PRIORITIES; l++)
        begin
            fill[l]   = fill_reg[l];
            head[l]   = slot_reg[l][0];
            second[l] = slot_reg[l][1 % QUEUE_DEPTH];
        end
    end

endmodule

`default_nettype wire

/* rtl/brprs_slice_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// brprs_slice_table: reload and remaining slice counters per task id
// depends on brprs_pkg

module brprs_slice_table #(
    parameter int MAX_TASKS = 16,
    localparam int TASK_SLOTS = (MAX_TASKS < 16) ? MAX_TASKS : 16,
    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
    input  logic                  clk,
    input  brprs_pkg::slice_cmd_t cmd,
    input  brprs_pkg::task_t      rd_task,
    output brprs_pkg::slice_t     rd_left
);
    import brprs_pkg::*;

    // task ids are four bits wide, so at most sixteen entries are reachable
    slice_t           reload_reg [TASK_SLOTS];
    slice_t           left_reg   [TASK_SLOTS];
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;

    assign wr_idx  = cmd.task_id[IDX_W-1:0];
    assign rd_idx  = rd_task[IDX_W-1:0];
    assign rd_left = left_reg[rd_idx];

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            SLICE_LOAD:
            begin
                reload_reg[wr_idx] <= cmd.value;
                left_reg[wr_idx]   <= cmd.value;
            end
            SLICE_DEC:
            begin
                left_reg[wr_idx] <= left_reg[wr_idx] - slice_t'(1);
            end
            SLICE_RELOAD:
            begin
                left_reg[wr_idx] <= reload_reg[wr_idx];
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/bitmap_priority_round_robin_scheduler_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// bitmap_priority_round_robin_scheduler_top: eight-level task scheduler with round-robin slices
// an accepted word passes the input register and the decision logic into the result register;
// throughput one word per cycle while out_ready holds, set by the single-pass state update
// reset clears the ready map, queue fills, current task and both valid flags;
// queue slots and slice counters hold garbage until written
// depends on brprs_pkg, brprs_ready_map, brprs_task_queues, brprs_slice_table

module bitmap_priority_round_robin_scheduler_top #(
    parameter int NUM_PRIORITIES = 8,
    parameter int QUEUE_DEPTH    = 16,
    parameter int MAX_TASKS      = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [brprs_pkg::KIND_W-1:0]      kind,
    input  logic [brprs_pkg::TASK_W-1:0]      task_id,
    input  logic [brprs_pkg::PRIO_IN_W-1:0]   priority_req,
    input  logic [brprs_pkg::SLICE_W-1:0]     slice_length,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [brprs_pkg::TASK_W-1:0]      current_task,
    output logic                              rotated,
    output logic [brprs_pkg::STATUS_W-1:0]    status
);
    import brprs_pkg::*;

    localparam int PRIO_W = $clog2(NUM_PRIORITIES);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    // input register
    logic   in_valid_reg;
    kind_t  kind_reg;
    task_t  task_id_reg;
    prio_t  prio_reg;
    slice_t slice_reg;

    // result register
    logic    out_valid_reg;
    task_t   current_task_reg;
    logic    rotated_reg;
    status_t status_reg;

    // scheduler state held here
    task_t running_reg;
    task_t running_next;

    logic    process;
    logic    rotated_next;
    status_t status_next;

    ready_cmd_t ready_cmd;
    queue_cmd_t queue_cmd;
    slice_cmd_t slice_cmd;

    logic              found;
    logic [PRIO_W-1:0] win_level;
    logic [FILL_W-1:0] fill [NUM_PRIORITIES];
    task_t             head [NUM_PRIORITIES];
    task_t             second [NUM_PRIORITIES];
    task_t             win_head;
    slice_t            win_left;

    logic [PRIO_W-1:0] req_level;
    logic              level_ok;
    logic              task_ok;
    logic              req_full;
    logic [FILL_W-1:0] win_fill;

    // the word in the input register moves on once the result slot is free
    assign process  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            kind_reg    <= kind_t'(kind);
            task_id_reg <= task_id;
            prio_reg    <= priority_req;
            slice_reg   <= slice_length;
        end
    end

    brprs_ready_map #(
        .NUM_PRIORITIES (NUM_PRIORITIES)
    ) u_ready_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ready_cmd),
        .found     (found),
        .win_level (win_level)
    );

    brprs_task_queues #(
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_task_queues (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (queue_cmd),
        .fill   (fill),
        .head   (head),
        .second (second)
    );

    brprs_slice_table #(
        .MAX_TASKS (MAX_TASKS)
    ) u_slice_table (
        .clk     (clk),
        .cmd     (slice_cmd),
        .rd_task (win_head),
        .rd_left (win_left)
    );

    // request checks for add and clear
    assign req_level = prio_reg[PRIO_W-1:0];
    assign level_ok  = int'(prio_reg) < NUM_PRIORITIES;
    assign task_ok   = int'(task_id_reg) < MAX_TASKS;
    assign req_full  = fill[req_level] == FILL_W'(QUEUE_DEPTH);

    // winning level for a switch tick
    assign win_fill = fill[win_level];
    assign win_head = head[win_level];

    always_comb
    begin
        running_next = running_reg;
        rotated_next = 1'b0;
        status_next  = STATUS_OK;

        ready_cmd.set     = 1'b0;
        ready_cmd.clr     = 1'b0;
        ready_cmd.level   = prio_reg;

        queue_cmd.push    = 1'b0;
        queue_cmd.rotate  = 1'b0;
        queue_cmd.level   = prio_reg;
        queue_cmd.task_id = task_id_reg;

        slice_cmd.op      = SLICE_HOLD;
        slice_cmd.task_id = task_id_reg;
        slice_cmd.value   = slice_reg;

        if (process)
        begin
            case (kind_reg)
                KIND_ADD:
                begin
                    if (!level_ok || !task_ok || req_full)
                    begin
                        status_next = STATUS_QUEUE_FULL;
                    end
                    else
                    begin
                        queue_cmd.push = 1'b1;
                        slice_cmd.op   = SLICE_LOAD;
                        ready_cmd.set  = 1'b1;
                    end
                end
                KIND_SWITCH:
                begin
                    queue_cmd.level   = PRIO_IN_W'(win_level);
                    queue_cmd.task_id = win_head;
                    slice_cmd.task_id = win_head;
                    if (!found || win_fill == '0)
                    begin
                        status_next = STATUS_NO_READY;
                    end
                    else if (win_left > slice_t'(1))
                    begin
                        // slice still running: count down, head stays current
                        slice_cmd.op = SLICE_DEC;
                        running_next = win_head;
                    end
                    else
                    begin
                        // slice used up: reload, move head to tail, next head runs
                        slice_cmd.op     = SLICE_RELOAD;
                        queue_cmd.rotate = 1'b1;
                        rotated_next     = 1'b1;
                        running_next     = (win_fill == FILL_W'(1)) ? win_head
                                                                     : second[win_level];
                    end
                end
                KIND_CLEAR:
                begin
                    ready_cmd.clr = level_ok;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            if (process)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            current_task_reg <= running_next;
            rotated_reg      <= rotated_next;
            status_reg       <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign current_task = current_task_reg;
    assign rotated      = rotated_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire
